@@ design/bsp_pkg.sv @@
// Shared types and constants for the budgeted slice planner.
`default_nettype none

package bsp_pkg;

    localparam int MAX_PIECES = 4096;
    localparam int FRAME_BITS = 20;
    localparam int PIECE_W = $clog2(MAX_PIECES + 1);
    localparam int BUDGET_W = 12;
    localparam int UNIT_W = 10;

    localparam logic [BUDGET_W-1:0] MIN_BUDGET = BUDGET_W'(17);
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(256);
    localparam logic [PIECE_W-1:0] CONTEXT_PIECES = PIECE_W'(2);
    localparam logic [PIECE_W-1:0] PIECE_LIMIT = PIECE_W'(MAX_PIECES);
    localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

    typedef struct packed {
        logic [UNIT_W-1:0] unit_len;
        logic              last_unit;
    } unit_t;

    typedef struct packed {
        logic [PIECE_W-1:0]    piece_begin;
        logic [PIECE_W-1:0]    piece_end;
        logic [FRAME_BITS-1:0] start_frame;
        logic [FRAME_BITS-1:0] stop_frame;
        logic                  final_slice;
        logic                  no_frames_error;
    } slice_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIECE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic take;
        logic flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_piece;
        logic fits;
        logic last;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

@@ design/bsp_ctrl.sv @@
// Controller state machine that sequences the pieces of one unit.
`default_nettype none

module bsp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  unit_valid,
    output logic                       unit_stall,
    input  wire bsp_pkg::ctrl_status_t status,
    output bsp_pkg::ctrl_cmd_t         cmd
);
    import bsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unit_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                unit_stall = 1'b0;
                if (unit_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_PIECE;
                end
            end
            ST_PIECE:
            begin
                if (!status.has_piece)
                begin
                    state_next = status.last ? ST_FLUSH : ST_IDLE;
                end
                else if (status.fits || status.out_free)
                begin
                    cmd.take = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/bsp_datapath.sv @@
// Datapath with the slice state, piece arithmetic and the output register.
`default_nettype none

module bsp_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bsp_pkg::unit_t         unit_item,
    input  wire logic                   cfg_valid,
    input  wire logic [11:0]            cfg_data,
    input  wire bsp_pkg::ctrl_cmd_t     cmd,
    output bsp_pkg::ctrl_status_t       status,
    output logic                        slice_valid,
    input  wire logic                   slice_stall,
    output bsp_pkg::slice_t             slice_item
);
    import bsp_pkg::*;

    logic [BUDGET_W-1:0]   budget_reg;
    logic [UNIT_W-1:0]     remaining_reg;
    logic                  last_reg;
    logic [PIECE_W-1:0]    pieces_seen_reg;
    logic [BUDGET_W-1:0]   open_frames_reg;
    logic [PIECE_W-1:0]    open_piece_begin_reg;
    logic [FRAME_BITS-1:0] open_frame_begin_reg;
    logic [FRAME_BITS-1:0] closed_frame_end_reg;
    logic [BUDGET_W-1:0]   piece_minus_one_reg;
    logic [BUDGET_W-1:0]   piece_minus_two_reg;
    logic                  out_valid_reg;
    slice_t                out_item_reg;

    logic [BUDGET_W-1:0]   budget;
    logic [BUDGET_W-1:0]   piece;
    logic [BUDGET_W:0]     open_sum;
    logic                  fits;
    logic [BUDGET_W:0]     ctx;
    logic [BUDGET_W+1:0]   ctx_with_piece;
    logic [PIECE_W-1:0]    span;
    logic                  use_context;
    logic [FRAME_BITS-1:0] slice_end;
    logic [FRAME_BITS-1:0] overlap_begin;
    logic [PIECE_W-1:0]    pieces_inc;
    logic                  out_free;

    function automatic logic [FRAME_BITS-1:0] frame_sat(
        input logic [FRAME_BITS-1:0] a,
        input logic [BUDGET_W-1:0]   b
    );
        logic [FRAME_BITS:0] s;
        s = {1'b0, a} + (FRAME_BITS + 1)'(b);
        return s[FRAME_BITS] ? FRAME_MAX : s[FRAME_BITS-1:0];
    endfunction

    assign budget = (budget_reg < MIN_BUDGET) ? MIN_BUDGET : budget_reg;
    assign piece = (BUDGET_W'(remaining_reg) > budget) ? budget : BUDGET_W'(remaining_reg);
    assign open_sum = {1'b0, open_frames_reg} + {1'b0, piece};
    assign fits = open_sum <= {1'b0, budget};
    assign ctx = {1'b0, piece_minus_one_reg} + {1'b0, piece_minus_two_reg};
    assign ctx_with_piece = {1'b0, ctx} + (BUDGET_W + 2)'(piece);
    assign span = pieces_seen_reg - open_piece_begin_reg;
    assign use_context = (span > CONTEXT_PIECES)
                         && (ctx_with_piece <= (BUDGET_W + 2)'(budget));
    assign slice_end = frame_sat(open_frame_begin_reg, open_frames_reg);
    assign overlap_begin = (slice_end >= FRAME_BITS'(ctx)) ? slice_end - FRAME_BITS'(ctx)
                                                            : '0;
    assign pieces_inc = (pieces_seen_reg < PIECE_LIMIT) ? pieces_seen_reg + PIECE_W'(1)
                                                        : pieces_seen_reg;
    assign out_free = !out_valid_reg || !slice_stall;

    always_comb
    begin
        status.has_piece = remaining_reg != '0;
        status.fits = fits;
        status.last = last_reg;
        status.out_free = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            remaining_reg <= '0;
            last_reg <= 1'b0;
            pieces_seen_reg <= '0;
            open_frames_reg <= '0;
            open_piece_begin_reg <= '0;
            open_frame_begin_reg <= '0;
            closed_frame_end_reg <= '0;
            piece_minus_one_reg <= '0;
            piece_minus_two_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                budget_reg <= cfg_data;
            end

            if (cmd.flush || (cmd.take && !fits))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!slice_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.load)
            begin
                remaining_reg <= unit_item.unit_len;
                last_reg <= unit_item.last_unit;
            end

            if (cmd.take)
            begin
                remaining_reg <= remaining_reg - piece[UNIT_W-1:0];
                piece_minus_two_reg <= piece_minus_one_reg;
                piece_minus_one_reg <= piece;
                pieces_seen_reg <= pieces_inc;
                if (fits)
                begin
                    if (open_frames_reg == '0)
                    begin
                        open_piece_begin_reg <= pieces_seen_reg;
                        open_frame_begin_reg <= closed_frame_end_reg;
                    end
                    open_frames_reg <= open_sum[BUDGET_W-1:0];
                end
                else
                begin
                    closed_frame_end_reg <= slice_end;
                    if (use_context)
                    begin
                        open_piece_begin_reg <= pieces_seen_reg - CONTEXT_PIECES;
                        open_frame_begin_reg <= overlap_begin;
                        open_frames_reg <= ctx_with_piece[BUDGET_W-1:0];
                    end
                    else
                    begin
                        open_piece_begin_reg <= pieces_seen_reg;
                        open_frame_begin_reg <= slice_end;
                        open_frames_reg <= piece;
                    end
                end
            end

            if (cmd.flush)
            begin
                last_reg <= 1'b0;
                pieces_seen_reg <= '0;
                open_frames_reg <= '0;
                open_piece_begin_reg <= '0;
                open_frame_begin_reg <= '0;
                closed_frame_end_reg <= '0;
                piece_minus_one_reg <= '0;
                piece_minus_two_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !fits)
        begin
            out_item_reg.piece_begin <= open_piece_begin_reg;
            out_item_reg.piece_end <= pieces_seen_reg;
            out_item_reg.start_frame <= open_frame_begin_reg;
            out_item_reg.stop_frame <= slice_end;
            out_item_reg.final_slice <= 1'b0;
            out_item_reg.no_frames_error <= 1'b0;
        end
        else if (cmd.flush)
        begin
            if (open_frames_reg != '0)
            begin
                out_item_reg.piece_begin <= open_piece_begin_reg;
                out_item_reg.piece_end <= pieces_seen_reg;
                out_item_reg.start_frame <= open_frame_begin_reg;
                out_item_reg.stop_frame <= slice_end;
                out_item_reg.no_frames_error <= 1'b0;
            end
            else
            begin
                out_item_reg.piece_begin <= '0;
                out_item_reg.piece_end <= '0;
                out_item_reg.start_frame <= '0;
                out_item_reg.stop_frame <= '0;
                out_item_reg.no_frames_error <= 1'b1;
            end
            out_item_reg.final_slice <= 1'b1;
        end
    end

    assign slice_valid = out_valid_reg;
    assign slice_item = out_item_reg;

endmodule

`default_nettype wire

@@ design/budgeted_slice_planner.sv @@
// Top level of the budgeted slice planner: controller, datapath and checks.
//
// Each item on the unit channel carries one unit frame count and a last flag.
// The unit is cut into pieces of at most the frame budget, and the pieces are
// packed into slices; every closed slice leaves as one item on the slice channel.
// The budget is written through the cfg channel, which is always ready.
// An accepted unit is loaded, its pieces are taken in order, the unit is then
// finished, and a flush follows when it is the last of its run;
// unit_stall stays high once the unit is loaded until the controller is idle again.
// A unit of 1023 frames at the smallest budget of 17 makes 61 pieces.
// A slice closed by a piece is valid in the cycle after that piece is taken,
// and the final slice of a run is registered by the flush after its last unit.
// Results pass through a single output register. When the receiver holds
// slice_stall high, a piece that closes a slice waits until the register frees,
// while pieces that only grow the open slice keep going.
// Reset clears the run state and the output valid flag and sets the budget to 256.
`default_nettype none

module budgeted_slice_planner (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            unit_valid,
    output logic                 unit_stall,
    input  wire bsp_pkg::unit_t  unit_item,
    output logic                 slice_valid,
    input  wire logic            slice_stall,
    output bsp_pkg::slice_t      slice_item,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [11:0]     cfg_data
);
    import bsp_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign cfg_ready = 1'b1;

    bsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .status     (status),
        .cmd        (cmd)
    );

    bsp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .unit_item   (unit_item),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .slice_valid (slice_valid),
        .slice_stall (slice_stall),
        .slice_item  (slice_item)
    );

`ifndef SYNTH
    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (slice_valid && slice_item.no_frames_error) |->
        (slice_item.final_slice && slice_item.piece_end == '0
         && slice_item.stop_frame == '0))
        else $error("error result is not a final empty slice");

    a_slice_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (slice_valid && !slice_item.no_frames_error) |->
        (slice_item.piece_begin <= slice_item.piece_end
         && slice_item.start_frame <= slice_item.stop_frame))
        else $error("slice ranges run backward");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (unit_valid && !unit_stall) |=> unit_stall)
        else $error("unit accepted before the previous one was planned");
`endif

endmodule

`default_nettype wire
